>>> hw/rtl/percent_decode_stream_unit_macros.svh
// Assertion macros for the percent decode stream unit.
`ifndef PERCENT_DECODE_STREAM_UNIT_MACROS_SVH
`define PERCENT_DECODE_STREAM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pds assertion failed");

// Next-cycle implication, checked outside reset.
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pds assertion failed");

`else

`define PDS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/pds_pkg.sv
// Shared types, codes and helpers for the percent decode stream unit.
package pds_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CAP_W   = 9;
    localparam int unsigned COUNT_W = 9;

    localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'h25;
    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] MIN_PRINT  = 8'd32;
    localparam logic [BYTE_W-1:0] DEL_CHAR   = 8'd127;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd65;

    // Configuration register indexes
    localparam logic CFG_PLUS_AS_SPACE = 1'b0;
    localparam logic CFG_CAPACITY      = 1'b1;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2
    } pds_phase_t;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } pds_status_t;

    typedef struct packed {
        pds_phase_t         phase;
        logic [3:0]         high_nibble;
        logic [COUNT_W-1:0] out_count;
        logic               failed;
    } pds_state_t;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        pds_status_t       status;
        logic              end_of_component;
    } pds_result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } pds_hex_t;

    localparam pds_state_t PDS_STATE_CLEAR = '{
        phase:       PH_NORMAL,
        high_nibble: 4'd0,
        out_count:   '0,
        failed:      1'b0
    };

    function automatic pds_hex_t hex_digit(input logic [BYTE_W-1:0] b);
        pds_hex_t h;
        h.bad = 1'b0;
        h.val = 4'd0;
        case (b) inside
            [8'h30:8'h39]: h.val = b[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: h.val = 4'(b[2:0] + 3'd1) + 4'd8;
            default:       h.bad = 1'b1;
        endcase
        return h;
    endfunction

endpackage

>>> hw/rtl/pds_decode.sv
// Escape decoder: next component state and result word for one source byte.
module pds_decode (
    input  pds_pkg::pds_state_t            state_i,
    input  logic [pds_pkg::BYTE_W-1:0]     byte_i,
    input  logic                           last_i,
    input  logic                           plus_as_space_i,
    input  logic [pds_pkg::CAP_W-1:0]      capacity_i,
    output pds_pkg::pds_state_t            state_next_o,
    output pds_pkg::pds_result_t           result_o
);
    import pds_pkg::*;

    pds_state_t        st;
    pds_hex_t          hex;
    logic              have;
    logic              emit;
    logic [BYTE_W-1:0] dec;
    logic [COUNT_W:0]  count_inc;

    assign hex       = hex_digit(byte_i);
    assign count_inc = {1'b0, state_i.out_count} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb begin
        st   = state_i;
        have = 1'b0;
        emit = 1'b0;
        dec  = '0;
        if (!state_i.failed) begin
            case (state_i.phase)
                PH_HIGH: begin
                    if (hex.bad) begin
                        st.failed = 1'b1;
                    end else begin
                        st.high_nibble = hex.val;
                        st.phase       = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (hex.bad) begin
                        st.failed = 1'b1;
                    end else begin
                        dec      = {state_i.high_nibble, hex.val};
                        st.phase = PH_NORMAL;
                        have     = 1'b1;
                    end
                end
                default: begin
                    if (byte_i == PCT_CHAR) begin
                        st.phase = PH_HIGH;
                    end else begin
                        dec  = (plus_as_space_i && byte_i == PLUS_CHAR) ? SPACE_CHAR : byte_i;
                        have = 1'b1;
                    end
                end
            endcase
            if (have) begin
                if (dec < MIN_PRINT || dec == DEL_CHAR
                        || count_inc >= {1'b0, capacity_i}) begin
                    st.failed = 1'b1;
                end else begin
                    emit         = 1'b1;
                    st.out_count = count_inc[COUNT_W-1:0];
                end
            end
            if (last_i && st.phase != PH_NORMAL) begin
                st.failed = 1'b1;
            end
        end
    end

    always_comb begin
        result_o.out_valid        = emit;
        result_o.out_byte         = emit ? dec : '0;
        result_o.status           = ST_RUN;
        if (last_i) begin
            result_o.status = st.failed ? ST_REJECT : ST_ACCEPT;
        end
        result_o.end_of_component = last_i;
    end

    assign state_next_o = last_i ? PDS_STATE_CLEAR : st;

endmodule

>>> hw/rtl/percent_decode_stream_unit.sv
// Top level of the percent decode stream unit: input register, decoder, output register.
//
// channel | dir | tdata           | tuser                         | tlast
// s_axis  | in  | [7:0] src_byte  | -                             | is_last
// m_axis  | out | [7:0] out_byte  | [0] out_valid, [2:1] status   | end_of_component
//
// One word in and one word out per cycle while m_axis is ready; a word passes through
// the input register and the output register, the decoder sitting between them.
// Component state updates as a word moves from the input to the output register.
// Reset empties both registers, clears the component state and sets the configuration to its defaults.
// A stall at m_axis holds the output word and backs up into the input register.
`include "percent_decode_stream_unit_macros.svh"

module percent_decode_stream_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [pds_pkg::CAP_W-1:0]     cfg_wdata,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] src_byte
    input  logic                          s_axis_tlast,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]                    m_axis_tuser,   // [0] out_valid, [2:1] status
    output logic                          m_axis_tlast
);
    import pds_pkg::*;

    logic              plus_as_space_reg;
    logic [CAP_W-1:0]  capacity_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    pds_state_t        state_reg;
    pds_state_t        state_next;
    pds_result_t       result;

    logic              out_valid_reg;
    pds_result_t       out_res_reg;

    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_as_space_reg <= 1'b0;
            capacity_reg      <= CAPACITY_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PLUS_AS_SPACE: plus_as_space_reg <= cfg_wdata[0];
                CFG_CAPACITY:      capacity_reg      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    pds_decode u_decode (
        .state_i         (state_reg),
        .byte_i          (in_byte_reg),
        .last_i          (in_last_reg),
        .plus_as_space_i (plus_as_space_reg),
        .capacity_i      (capacity_reg),
        .state_next_o    (state_next),
        .result_o        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PDS_STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.out_byte;
    assign m_axis_tuser  = {out_res_reg.status, out_res_reg.out_valid};
    assign m_axis_tlast  = out_res_reg.end_of_component;

    // Only the word that ends a component carries a final status.
    `PDS_ASSERT_NOW(a_status_on_last, aclk, aresetn, m_axis_tvalid && !m_axis_tlast, out_res_reg.status == ST_RUN)

    // A rejected component emits nothing more.
    `PDS_ASSERT_NOW(a_no_emit_after_fail, aclk, aresetn, advance && state_reg.failed, !result.out_valid)

    // Emitted bytes are printable.
    `PDS_ASSERT_NOW(a_emit_printable, aclk, aresetn, m_axis_tvalid && out_res_reg.out_valid, out_res_reg.out_byte >= MIN_PRINT && out_res_reg.out_byte != DEL_CHAR)

    // The last word of a component leaves the state cleared.
    `PDS_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, advance && in_last_reg, state_reg == PDS_STATE_CLEAR)

endmodule
